@@ hdl/assert_macros.svh @@
// assertion macros used by the port checker, plid_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequence is checked at the following clock edge
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/plid_pkg.sv @@
// shared types and constants for the positional list
`default_nettype none
package plid_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic                     opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         list_length;
  } out_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [POS_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ hdl/positional_list_insert_delete.sv @@
// top level of the positional list
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Input channel: in_item (opcode, position, new_value) is taken at a rising
// edge where start is high and busy is low. busy never rises, so one
// transaction can be taken every cycle.
// Insert places new_value at one-based position 1..length+1; delete removes
// the entry at 1..length and returns it. Rejected transactions (full list or
// bad position) change nothing.
// Result channel: out_item (status, removed_value, list_length) appears for
// one cycle with out_valid high, in the cycle after the transaction is taken.
// Throughput is 1 transaction per cycle: every cell that changes
// loads or shifts from a neighbor in the same edge.
// The receiver cannot stall; each result must be taken when shown.
// Synchronous reset empties the list and drops out_valid; cell contents are
// not cleared, entries past the length are never returned.
`default_nettype none
module positional_list_insert_delete (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  plid_pkg::in_t   in_item,
  output logic            out_valid,
  output plid_pkg::out_t  out_item
);

  localparam int N = plid_pkg::CAPACITY;

  logic [plid_pkg::CNT_W-1:0] count_r;
  logic [plid_pkg::CNT_W-1:0] count_nxt;
  logic                       out_valid_r;
  plid_pkg::out_t             out_r;
  plid_pkg::out_t             out_nxt;
  plid_pkg::cell_cmd_t        cmd;
  plid_pkg::status_t          status;
  logic                       accept;
  logic [plid_pkg::POS_W:0]   pos_ext;
  logic [plid_pkg::POS_W:0]   cnt_ext;

  logic signed [plid_pkg::DATA_W-1:0] cell_val [N];
  logic                               cell_hit [N];
  logic signed [plid_pkg::DATA_W-1:0] removed;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_ext = {1'b0, in_item.position};
  assign cnt_ext = (plid_pkg::POS_W + 1)'(count_r);

  always_comb begin
    status = plid_pkg::ST_OK;
    if (in_item.opcode == plid_pkg::OP_INSERT) begin
      if (cnt_ext >= (plid_pkg::POS_W + 1)'(N)) begin
        status = plid_pkg::ST_FULL;
      end else if (in_item.position == '0 || pos_ext > cnt_ext + 1'b1) begin
        status = plid_pkg::ST_RANGE;
      end
    end else begin
      if (in_item.position == '0 || pos_ext > cnt_ext) begin
        status = plid_pkg::ST_RANGE;
      end
    end
  end

  always_comb begin
    cmd.ins   = accept && (in_item.opcode == plid_pkg::OP_INSERT)
                && (status == plid_pkg::ST_OK);
    cmd.del   = accept && (in_item.opcode == plid_pkg::OP_DELETE)
                && (status == plid_pkg::ST_OK);
    cmd.idx   = in_item.position - 1'b1;
    cmd.value = in_item.new_value;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    plid_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot      (plid_pkg::POS_W'(k)),
      .left_val  ((k == 0) ? in_item.new_value : cell_val[(k == 0) ? 0 : k - 1]),
      .right_val ((k == N - 1) ? cell_val[k] : cell_val[(k == N - 1) ? k : k + 1]),
      .val       (cell_val[k]),
      .hit       (cell_hit[k])
    );
  end

  // one-hot pick of the entry being removed
  always_comb begin
    removed = '0;
    for (int k = 0; k < N; k++) begin
      removed = removed | (cell_val[k] & {plid_pkg::DATA_W{cell_hit[k]}});
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.del) begin
      count_nxt = count_r - 1'b1;
    end
    out_nxt.status        = status;
    out_nxt.removed_value = cmd.del ? removed : '0;
    out_nxt.list_length   = plid_pkg::POS_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

@@ hdl/plid_cell.sv @@
// one list slot: loads, shifts from a neighbor or holds
`default_nettype none
module plid_cell (
  input  logic                             clk,
  input  plid_pkg::cell_cmd_t              cmd,
  input  logic [plid_pkg::POS_W-1:0]       slot,
  input  logic signed [plid_pkg::DATA_W-1:0] left_val,
  input  logic signed [plid_pkg::DATA_W-1:0] right_val,
  output logic signed [plid_pkg::DATA_W-1:0] val,
  output logic                             hit
);

  logic signed [plid_pkg::DATA_W-1:0] val_r;
  logic signed [plid_pkg::DATA_W-1:0] val_nxt;

  assign hit = (slot == cmd.idx);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (slot == cmd.idx) begin
        val_nxt = cmd.value;
      end else if (slot > cmd.idx) begin
        val_nxt = left_val;
      end
    end else if (cmd.del) begin
      if (slot >= cmd.idx) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/plid_checker.sv @@
// port-level checks for the positional list, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module plid_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input plid_pkg::out_t out_item
);

  logic                       accepted;
  logic                       rejected;
  logic                       full_seen;
  logic                       len_ok;
  logic                       len_full;
  logic                       value_zero;
  logic [plid_pkg::POS_W-1:0] cap_len;

  assign accepted   = start && !busy;
  assign rejected   = out_valid && out_item.status != plid_pkg::ST_OK;
  assign full_seen  = out_valid && out_item.status == plid_pkg::ST_FULL;
  assign cap_len    = plid_pkg::POS_W'(plid_pkg::CAPACITY);
  assign len_ok     = out_item.list_length <= cap_len;
  assign len_full   = out_item.list_length == cap_len;
  assign value_zero = out_item.removed_value == '0;

  `PLID_ASSERT_NEXT(a_one_result, accepted, out_valid, "missing result after transaction")
  `PLID_ASSERT_NEXT(a_no_extra, !accepted, !out_valid, "result without transaction")
  `PLID_ASSERT(a_len_cap, !out_valid || len_ok, "length above capacity")
  `PLID_ASSERT(a_full_len, !full_seen || len_full, "full status with short list")
  `PLID_ASSERT(a_reject_zero, !rejected || value_zero, "rejected transaction returned a value")

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

@@ tb/list_checker.sv @@
// checker for the positional list: predicts each result and compares it
`timescale 1ns / 100ps
module list_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  plid_pkg::in_t  in_item,
  input  logic           out_valid,
  input  plid_pkg::out_t out_item,
  output int             pending,
  output int             fails,
  output int             n_inserts,
  output int             n_deletes,
  output int             n_full,
  output int             n_range,
  output int             peak_len
);

  logic signed [plid_pkg::DATA_W-1:0] list_words [plid_pkg::CAPACITY];
  int                                 list_len;
  plid_pkg::out_t                     expected_results [$];
  plid_pkg::out_t                     oldest;
  plid_pkg::out_t                     predicted;

  initial begin
    pending   = 0;
    fails     = 0;
    n_inserts = 0;
    n_deletes = 0;
    n_full    = 0;
    n_range   = 0;
    peak_len  = 0;
    list_len  = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h, wanted %0h", $realtime, what, got, want);
    fails++;
  endtask

  // applies one transaction to the predicted list and returns its result
  function automatic plid_pkg::out_t apply_list_op(input plid_pkg::in_t t);
    plid_pkg::out_t r;
    int             k;
    r.status        = plid_pkg::ST_OK;
    r.removed_value = '0;
    if (t.opcode == plid_pkg::OP_INSERT) begin
      if (list_len >= plid_pkg::CAPACITY) begin
        r.status = plid_pkg::ST_FULL;
      end else if (t.position < 1 || int'(t.position) > list_len + 1) begin
        r.status = plid_pkg::ST_RANGE;
      end else begin
        for (k = list_len; k >= int'(t.position); k--)
          list_words[k] = list_words[k-1];
        list_words[t.position-1] = t.new_value;
        list_len++;
      end
    end else begin
      if (t.position < 1 || int'(t.position) > list_len) begin
        r.status = plid_pkg::ST_RANGE;
      end else begin
        r.removed_value = list_words[t.position-1];
        for (k = int'(t.position) - 1; k < list_len - 1; k++)
          list_words[k] = list_words[k+1];
        list_len--;
      end
    end
    r.list_length = plid_pkg::POS_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      list_len = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(out_item.status), '0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_item.status !== oldest.status)
            report_mismatch("status", 64'(out_item.status), 64'(oldest.status));
          if (out_item.removed_value !== oldest.removed_value)
            report_mismatch("removed_value", 64'(out_item.removed_value),
                            64'(oldest.removed_value));
          if (out_item.list_length !== oldest.list_length)
            report_mismatch("list_length", 64'(out_item.list_length),
                            64'(oldest.list_length));
        end
      end
      if (start && !busy) begin
        predicted = apply_list_op(in_item);
        expected_results.push_back(predicted);
        if (in_item.opcode == plid_pkg::OP_INSERT) n_inserts++;
        else n_deletes++;
        if (predicted.status == plid_pkg::ST_FULL) n_full++;
        if (predicted.status == plid_pkg::ST_RANGE) n_range++;
        if (list_len > peak_len) peak_len = list_len;
      end
      pending <= expected_results.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// top of the positional list testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;

  logic           clk     = 1'b0;
  logic           rst_n   = 1'b0;
  logic           start   = 1'b0;
  plid_pkg::in_t  in_item = '0;
  logic           busy;
  logic           out_valid;
  plid_pkg::out_t out_item;

  int pending;
  int fails;
  int n_inserts;
  int n_deletes;
  int n_full;
  int n_range;
  int peak_len;
  int len_est;

  positional_list_insert_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  list_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .pending   (pending),
    .fails     (fails),
    .n_inserts (n_inserts),
    .n_deletes (n_deletes),
    .n_full    (n_full),
    .n_range   (n_range),
    .peak_len  (peak_len)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // drives one transaction and returns at the edge that accepts it
  task automatic send_command(input logic op, input logic [plid_pkg::POS_W-1:0] pos,
                              input logic signed [plid_pkg::DATA_W-1:0] val);
    start   <= 1'b1;
    in_item <= '{opcode: op, position: pos, new_value: val};
    do @(posedge clk); while (busy);
    if (op == plid_pkg::OP_INSERT) begin
      if (len_est < plid_pkg::CAPACITY && pos >= 1 && int'(pos) <= len_est + 1)
        len_est++;
    end else begin
      if (pos >= 1 && int'(pos) <= len_est) len_est--;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int                                 i;
    int                                 insert_bias;
    logic                               op;
    logic [plid_pkg::POS_W-1:0]         pos;
    logic signed [plid_pkg::DATA_W-1:0] val;

    len_est = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad positions, inserts and deletes at front, middle and end, extremes of the value
    send_command(plid_pkg::OP_DELETE, 6'd1, 32'sd0);
    send_command(plid_pkg::OP_DELETE, 6'd0, 32'sd0);
    send_command(plid_pkg::OP_INSERT, 6'd0, 32'sd5);
    send_command(plid_pkg::OP_INSERT, 6'd2, 32'sd5);
    send_command(plid_pkg::OP_INSERT, 6'd1, 32'h7fffffff);
    send_command(plid_pkg::OP_INSERT, 6'd2, 32'h80000000);
    send_command(plid_pkg::OP_INSERT, 6'd1, -32'sd1);
    send_command(plid_pkg::OP_INSERT, 6'd2, 32'sd0);
    send_command(plid_pkg::OP_INSERT, 6'd63, 32'h2aaaaaaa);
    send_command(plid_pkg::OP_INSERT, 6'd6, 32'h12345678);
    send_command(plid_pkg::OP_INSERT, 6'd5, 32'h55555555);
    send_command(plid_pkg::OP_DELETE, 6'd63, 32'hffffffff);
    send_command(plid_pkg::OP_DELETE, 6'd6, 32'sd0);
    send_command(plid_pkg::OP_DELETE, 6'd5, 32'sd0);
    send_command(plid_pkg::OP_DELETE, 6'd1, 32'sd0);
    send_command(plid_pkg::OP_DELETE, 6'd2, 32'sd0);
    send_command(plid_pkg::OP_DELETE, 6'd0, 32'sd0);
    send_command(plid_pkg::OP_INSERT, 6'd3, 32'haaaaaaaa);

    // alternating fill and drain phases so the list hits full and empty
    for (i = 0; i < 1950; i++) begin
      insert_bias = ((i / 150) % 2 == 0) ? 75 : 25;
      op = ($urandom_range(0, 99) < insert_bias) ? plid_pkg::OP_INSERT
                                                 : plid_pkg::OP_DELETE;
      if ($urandom_range(0, 99) < 85) begin
        if (op == plid_pkg::OP_INSERT)
          pos = plid_pkg::POS_W'($urandom_range(1, len_est + 1));
        else if (len_est == 0) pos = 1;
        else pos = plid_pkg::POS_W'($urandom_range(1, len_est));
      end else begin
        pos = plid_pkg::POS_W'($urandom_range(0, 63));
      end
      case ($urandom_range(0, 9))
        0: val = 32'h80000000;
        1: val = 32'h7fffffff;
        default: val = $urandom;
      endcase
      if (i == 500) drain_results();
      if (i < 900 || i >= 1200) begin
        while ($urandom_range(0, 99) < 29) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
      send_command(op, pos, val);
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d inserts and %0d deletes, %0d full-list and %0d range rejects",
             n_inserts, n_deletes, n_full, n_range);
    $display("list length peaked at %0d of %0d entries", peak_len, plid_pkg::CAPACITY);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fails);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
